### sv/rcqpe_pkg.sv
// Shared types and constants for the quad packet encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rcqpe_pkg;

   localparam int unsigned CHAN_FULL_SCALE_DEF = 10000;
   localparam int unsigned PAYLOAD_BYTES       = 15;
   localparam int unsigned BYTE_IDX_W          = 4;
   localparam int unsigned CHAN_W              = 15;
   localparam int unsigned SUM_W               = CHAN_W + 1;
   localparam int unsigned N_CHAN              = 10;
   localparam int unsigned REQ_DATA_W          = 152;
   localparam int unsigned RSP_DATA_W          = 24;
   localparam int unsigned RF_CHAN_W           = 7;
   localparam int unsigned BIND_CNT_W          = 10;

   // Scaling lanes: quotient = floor(span * (c + FS) / (2 * FS)).
   localparam int unsigned PROD_A_W    = 8 + CHAN_W;
   localparam int unsigned RECIP_SHIFT = PROD_A_W;
   localparam int unsigned RECIP_W     = 16;
   localparam int unsigned PROD_B_W    = PROD_A_W + RECIP_W;

   // Channel positions inside req_tdata.
   localparam int unsigned CH_AIL   = 0;
   localparam int unsigned CH_ELE   = 1;
   localparam int unsigned CH_THR   = 2;
   localparam int unsigned CH_RUD   = 3;
   localparam int unsigned CH_LED   = 4;
   localparam int unsigned CH_FLIP  = 5;
   localparam int unsigned CH_STILL = 6;
   localparam int unsigned CH_VIDEO = 7;
   localparam int unsigned CH_HEAD  = 8;
   localparam int unsigned CH_RATE  = 9;

   // Lane assignment.
   localparam int unsigned N_LANES  = 7;
   localparam int unsigned LN_THR   = 0;
   localparam int unsigned LN_YAW   = 1;
   localparam int unsigned LN_ELE   = 2;
   localparam int unsigned LN_AIL   = 3;
   localparam int unsigned LN_TRUD  = 4;
   localparam int unsigned LN_TELE  = 5;
   localparam int unsigned LN_TAIL  = 6;
   localparam int unsigned LANE_CHAN [N_LANES] =
      '{CH_THR, CH_RUD, CH_ELE, CH_AIL, CH_RUD, CH_ELE, CH_AIL};
   localparam int unsigned LANE_SPAN [N_LANES] = '{255, 120, 120, 120, 32, 64, 64};

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_FORMAT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DYNAMIC_TRIM = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ID_FIRST     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ID_SECOND    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIND_PACKETS = 3'd4;

   localparam logic [7:0]            ID_FIRST_RST  = 8'h80;
   localparam logic [BIND_CNT_W-1:0] BIND_PKTS_RST = 10'd800;

   // Packet bytes.
   localparam logic [7:0] HDR_BIND      = 8'hAA;
   localparam logic [7:0] HDR_DATA      = 8'h55;
   localparam logic [7:0] ID_ALIAS_FROM = 8'hAA;
   localparam logic [7:0] ID_ALIAS_TO   = 8'hAB;
   localparam logic [7:0] YAW_POS_BASE  = 8'h44;
   localparam logic [7:0] YAW_NEG_BASE  = 8'h3C;
   localparam logic [7:0] ELE_BASE      = 8'hBB;
   localparam logic [7:0] AIL_BASE      = 8'h43;
   localparam logic [7:0] AIL_REV       = 8'hFE;
   localparam logic [7:0] FILL_BYTE     = 8'h20;
   localparam logic [7:0] TRIM_RUD_BASE = 8'h10;
   localparam logic [7:0] TRIM_PIT_BASE = 8'h60;
   localparam logic [7:0] TRIM_RUD_NEUT = 8'h20;
   localparam logic [7:0] TRIM_PIT_NEUT = 8'h40;

   localparam logic [RF_CHAN_W-1:0] BIND_RF_CHAN = 7'h2D;
   localparam logic [7:0]           RF_CHAN_OFS  = 8'h7D;

   // Flag bits, first layout.
   localparam logic [7:0] F0_RATE_MID = 8'h20;
   localparam logic [7:0] F0_RATE_HI  = 8'h40;
   localparam logic [7:0] F0_LED_OFF  = 8'h10;
   localparam logic [7:0] F0_FLIP     = 8'h01;
   localparam logic [7:0] F0_STILL    = 8'h08;
   localparam logic [7:0] F0_VIDEO    = 8'h04;
   localparam logic [7:0] F0_HEADLESS = 8'h02;
   // Flag bits, second layout.
   localparam logic [7:0] F1_RATE_MID = 8'h04;
   localparam logic [7:0] F1_RATE_HI  = 8'h08;
   localparam logic [7:0] F1_FLIP     = 8'h01;
   localparam logic [7:0] F1_STILL    = 8'h40;
   localparam logic [7:0] F1_VIDEO    = 8'h80;
   localparam logic [7:0] F1_HEADLESS = 8'h20;

   typedef logic [N_LANES-1:0][7:0] lane_q_type;

   typedef struct packed {
      logic is_bind;
      logic rud_pos;
      logic rate_pos;
      logic rate_mid;
      logic led;
      logic flip;
      logic still;
      logic video;
      logic headless;
   } side_type;

   typedef struct packed {
      logic       frame_format;
      logic       dynamic_trim;
      logic [7:0] id_first;
      logic [7:0] id_second;
   } cfg_type;

   typedef struct packed {
      logic [PAYLOAD_BYTES-1:0][7:0] bytes;
      logic [RF_CHAN_W-1:0]          rf_chan;
      logic                          is_bind;
   } pkt_type;

endpackage
`default_nettype wire

### sv/rcqpe_lane.sv
// One scaling lane: saturates a stick value and finds floor(span*(c+FS)/(2*FS)).
// Three register stages; depends on rcqpe_pkg.
`default_nettype none
module rcqpe_lane #(
   parameter int unsigned FULL_SCALE = rcqpe_pkg::CHAN_FULL_SCALE_DEF,
   parameter int unsigned SPAN       = 120
) (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [rcqpe_pkg::CHAN_W-1:0] chan_raw,
   output logic             [7:0]                   q
);
   import rcqpe_pkg::*;

   localparam int unsigned DIVISOR = 2 * FULL_SCALE;
   localparam int unsigned RECIP   = (1 << RECIP_SHIFT) / DIVISOR;
   localparam logic signed [SUM_W-1:0] FS_S = SUM_W'(FULL_SCALE);

   logic signed [SUM_W-1:0]    chan_ext;
   logic signed [SUM_W-1:0]    chan_sat;
   logic signed [SUM_W-1:0]    x_s;
   logic        [PROD_A_W-1:0] n_in;
   logic        [PROD_A_W-1:0] n1_ff;
   logic        [PROD_A_W-1:0] n2_ff;
   logic        [PROD_B_W-1:0] prod_b;
   logic        [PROD_A_W-1:0] rem;
   logic        [7:0]          q0_ff;
   logic        [7:0]          q_in;
   logic        [7:0]          q_ff;

   always_comb begin
      chan_ext = SUM_W'(chan_raw);
      if (chan_ext > FS_S) begin
         chan_sat = FS_S;
      end else if (chan_ext < -FS_S) begin
         chan_sat = -FS_S;
      end else begin
         chan_sat = chan_ext;
      end
      x_s  = chan_sat + FS_S;
      n_in = PROD_A_W'(SPAN) * PROD_A_W'(x_s[CHAN_W-1:0]);
      // Reciprocal estimate is low by at most one; the remainder fixes it.
      prod_b = PROD_B_W'(n1_ff) * PROD_B_W'(RECIP);
      rem    = n2_ff - PROD_A_W'(q0_ff) * PROD_A_W'(DIVISOR);
      q_in   = (rem >= PROD_A_W'(DIVISOR)) ? q0_ff + 8'd1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= n_in;
         n2_ff <= n1_ff;
         q0_ff <= prod_b[RECIP_SHIFT +: 8];
         q_ff  <= q_in;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

### sv/rcqpe_merge.sv
// Merging stage: combines lane quotients, switch bits and configuration into
// one registered 15-byte packet. Depends on rcqpe_pkg.
`default_nettype none
module rcqpe_merge (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire rcqpe_pkg::lane_q_type q,
   input  wire rcqpe_pkg::side_type   side,
   input  wire rcqpe_pkg::cfg_type    cfg,
   output rcqpe_pkg::pkt_type         pkt
);
   import rcqpe_pkg::*;

   pkt_type    pkt_in;
   pkt_type    pkt_ff;
   logic [7:0] id0;
   logic [7:0] ail;
   logic [7:0] flags;

   always_comb begin
      id0   = (cfg.id_first == ID_ALIAS_FROM) ? ID_ALIAS_TO : cfg.id_first;
      ail   = AIL_BASE + q[LN_AIL];
      flags = '0;
      if (!cfg.frame_format) begin
         if (side.rate_pos) begin
            if (side.rate_mid) begin
               flags = flags | F0_RATE_MID;
            end
         end else begin
            flags = flags | F0_RATE_HI;
         end
         if (side.led)      flags = flags | F0_LED_OFF;
         if (side.flip)     flags = flags | F0_FLIP;
         if (side.still)    flags = flags | F0_STILL;
         if (side.video)    flags = flags | F0_VIDEO;
         if (side.headless) flags = flags | F0_HEADLESS;
      end else begin
         if (side.rate_pos) begin
            if (side.rate_mid) begin
               flags = flags | F1_RATE_MID;
            end
         end else begin
            flags = flags | F1_RATE_HI;
         end
         if (side.flip)     flags = flags | F1_FLIP;
         if (side.still)    flags = flags | F1_STILL;
         if (side.video)    flags = flags | F1_VIDEO;
         if (side.headless) flags = flags | F1_HEADLESS;
      end

      pkt_in          = '0;
      pkt_in.is_bind  = side.is_bind;
      pkt_in.rf_chan  = side.is_bind ? BIND_RF_CHAN : RF_CHAN_W'(id0 - RF_CHAN_OFS);
      pkt_in.bytes[0] = side.is_bind ? HDR_BIND : HDR_DATA;
      pkt_in.bytes[1] = id0;
      pkt_in.bytes[2] = cfg.id_second;
      pkt_in.bytes[5] = q[LN_THR];
      pkt_in.bytes[6] = side.rud_pos ? YAW_POS_BASE + q[LN_YAW] : YAW_NEG_BASE - q[LN_YAW];
      pkt_in.bytes[7] = ELE_BASE - q[LN_ELE];
      pkt_in.bytes[8] = cfg.frame_format ? AIL_REV - ail : ail;
      pkt_in.bytes[9] = FILL_BYTE;
      if (cfg.dynamic_trim) begin
         pkt_in.bytes[10] = TRIM_RUD_BASE + q[LN_TRUD];
         pkt_in.bytes[11] = TRIM_PIT_BASE - q[LN_TELE];
         pkt_in.bytes[12] = TRIM_PIT_BASE - q[LN_TAIL];
      end else begin
         pkt_in.bytes[10] = TRIM_RUD_NEUT;
         pkt_in.bytes[11] = TRIM_PIT_NEUT;
         pkt_in.bytes[12] = TRIM_PIT_NEUT;
      end
      pkt_in.bytes[13] = flags;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt = pkt_ff;

endmodule
`default_nettype wire

### sv/rc_quad_packet_encoder.sv
// The first byte of a packet is shown once its tick beat has passed the lane stages,
// the merge register and the serializer register. One packet byte goes out per cycle
// while rsp_tready is high; the next packet loads as the last held byte is taken.
// Up to five packets can be in flight between the lanes, the merge register and the output.
// Reset is synchronous and active high; it clears the link phase and the valid bits and
// loads the configuration defaults, after which the block takes beats at once.
`default_nettype none
module rc_quad_packet_encoder #(
   parameter int unsigned CHAN_FULL_SCALE = rcqpe_pkg::CHAN_FULL_SCALE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // aileron, elevator, throttle, rudder, led_switch, flip_switch,
   // still_switch, video_switch, headless_switch, rate_switch (15 bits each), 2 zero bits
   input  wire logic [rcqpe_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // payload_byte [7:0], byte_index [11:8], radio_channel [18:12], 5 zero bits
   output logic      [rcqpe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // is_bind
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [rcqpe_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [rcqpe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rcqpe_pkg::*;

   // The tick stream walks three link phases: a load of the bind counter, a run
   // of bind packets, and data packets for good.
   typedef enum logic [1:0] {
      PH_INIT = 2'd0,
      PH_BIND = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   localparam logic signed [CHAN_W-1:0] HALF_S = CHAN_W'(CHAN_FULL_SCALE / 2);
   localparam logic [BYTE_IDX_W-1:0]    LAST_IDX = BYTE_IDX_W'(PAYLOAD_BYTES - 1);

   // Configuration registers.
   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [BIND_CNT_W-1:0] bind_pkts_ff;
   logic [BIND_CNT_W-1:0] bind_pkts_in;

   // Link phase.
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [BIND_CNT_W-1:0] binds_left_ff;
   logic [BIND_CNT_W-1:0] binds_left_in;

   // Lane pipeline control: three stages share one advance enable.
   logic                  accept;
   logic                  emit;
   logic                  emit_bind;
   logic                  pipe_en;
   logic                  v1_ff, v2_ff, v3_ff;
   logic                  v1_in, v2_in, v3_in;
   side_type              side0;
   side_type              side1_ff, side2_ff, side3_ff;

   logic signed [CHAN_W-1:0] chan [N_CHAN];
   lane_q_type            lane_q;

   // Packet register between merge and serializer.
   logic                  m_free;
   logic                  mv_ff, mv_in;
   pkt_type               pkt;

   // Serializer: one byte per beat out of the held packet.
   logic                  s_load;
   logic                  sv_ff, sv_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   pkt_type               ser_ff;
   logic [7:0]            out_byte;

   always_comb begin
      for (int i = 0; i < N_CHAN; i++) begin
         chan[i] = req_tdata[i*CHAN_W +: CHAN_W];
      end
   end

   // Handshake chain, from the output back toward the input.
   assign s_load     = !sv_ff || (rsp_tready && (idx_ff == LAST_IDX));
   assign m_free     = !mv_ff || s_load;
   assign pipe_en    = !v3_ff || m_free;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && req_tready;

   // Switch decisions need no saturation: clamping keeps the sign, and half of
   // full scale lies inside the clamp range.
   always_comb begin
      side0.is_bind  = emit_bind;
      side0.rud_pos  = !chan[CH_RUD][CHAN_W-1] && (chan[CH_RUD] != '0);
      side0.rate_pos = !chan[CH_RATE][CHAN_W-1] && (chan[CH_RATE] != '0);
      side0.rate_mid = chan[CH_RATE] < HALF_S;
      side0.led      = !chan[CH_LED][CHAN_W-1] && (chan[CH_LED] != '0);
      side0.flip     = !chan[CH_FLIP][CHAN_W-1] && (chan[CH_FLIP] != '0);
      side0.still    = !chan[CH_STILL][CHAN_W-1] && (chan[CH_STILL] != '0);
      side0.video    = !chan[CH_VIDEO][CHAN_W-1] && (chan[CH_VIDEO] != '0);
      side0.headless = !chan[CH_HEAD][CHAN_W-1] && (chan[CH_HEAD] != '0);
   end

   // Link phase and configuration next state.
   always_comb begin
      phase_in      = phase_ff;
      binds_left_in = binds_left_ff;
      emit          = 1'b0;
      emit_bind     = 1'b0;
      case (phase_ff)
         PH_INIT: begin
            if (accept) begin
               binds_left_in = bind_pkts_ff;
               phase_in      = PH_BIND;
            end
         end
         PH_BIND: begin
            if (binds_left_ff == '0) begin
               if (accept) begin
                  phase_in = PH_DATA;
               end
            end else begin
               emit      = 1'b1;
               emit_bind = 1'b1;
               if (accept) begin
                  binds_left_in = binds_left_ff - 1'b1;
               end
            end
         end
         PH_DATA: begin
            emit = 1'b1;
         end
         default: begin
            // The spare phase code behaves as data mode.
            emit = 1'b1;
         end
      endcase

      cfg_in       = cfg_ff;
      bind_pkts_in = bind_pkts_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_FORMAT: cfg_in.frame_format = csr_wdata[0];
            CSR_DYNAMIC_TRIM: cfg_in.dynamic_trim = csr_wdata[0];
            CSR_ID_FIRST:     cfg_in.id_first     = csr_wdata[7:0];
            CSR_ID_SECOND:    cfg_in.id_second    = csr_wdata[7:0];
            CSR_BIND_PACKETS: bind_pkts_in        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Pipeline, packet register and serializer next state.
   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      if (pipe_en) begin
         v1_in = accept && emit;
         v2_in = v1_ff;
         v3_in = v2_ff;
      end
      mv_in = m_free ? v3_ff : mv_ff;

      sv_in  = sv_ff;
      idx_in = idx_ff;
      if (s_load) begin
         sv_in  = mv_ff;
         idx_in = '0;
      end else if (rsp_tready) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_INIT;
         binds_left_ff  <= '0;
         cfg_ff         <= '{frame_format: 1'b0, dynamic_trim: 1'b0,
                             id_first: ID_FIRST_RST, id_second: 8'h00};
         bind_pkts_ff   <= BIND_PKTS_RST;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         mv_ff          <= 1'b0;
         sv_ff          <= 1'b0;
         idx_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         binds_left_ff  <= binds_left_in;
         cfg_ff         <= cfg_in;
         bind_pkts_ff   <= bind_pkts_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         mv_ff          <= mv_in;
         sv_ff          <= sv_in;
         idx_ff         <= idx_in;
      end
   end

   // Side data rides along the lane stages; the held packet needs no reset.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side1_ff <= side0;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
      if (s_load) begin
         ser_ff <= pkt;
      end
   end

   // One lane per scaled byte: throttle, yaw, elevator, aileron and three trims.
   for (genvar g = 0; g < N_LANES; g++) begin : g_lane
      rcqpe_lane #(
         .FULL_SCALE (CHAN_FULL_SCALE),
         .SPAN       (LANE_SPAN[g])
      ) u_lane (
         .clock    (clock),
         .en       (pipe_en),
         .chan_raw (chan[LANE_CHAN[g]]),
         .q        (lane_q[g])
      );
   end

   rcqpe_merge u_merge (
      .clock (clock),
      .load  (m_free),
      .q     (lane_q),
      .side  (side3_ff),
      .cfg   (cfg_ff),
      .pkt   (pkt)
   );

   assign out_byte   = ser_ff.bytes[idx_ff];
   assign rsp_tvalid = sv_ff;
   assign rsp_tuser  = ser_ff.is_bind;
   assign rsp_tlast  = (idx_ff == LAST_IDX);
   assign rsp_tdata  = {(RSP_DATA_W - 8 - BYTE_IDX_W - RF_CHAN_W)'(0), ser_ff.rf_chan,
                        idx_ff, out_byte};

endmodule
`default_nettype wire

### sv/rcqpe_checker.sv
// Port-level checks on the encoder's result stream, bound to the top level.
// Depends on rcqpe_pkg and rc_quad_packet_encoder.
`default_nettype none
module rcqpe_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic [rcqpe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready
);
   import rcqpe_pkg::*;

   // A stalled beat keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // The last beat of a packet is exactly byte fourteen.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[11:8] == 4'(PAYLOAD_BYTES - 1))))
      else $error("tlast does not match byte position");

   // Bytes of one packet follow without gaps.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[11:8] == $past(rsp_tdata[11:8]) + 4'd1))
      else $error("packet byte sequence broken");

   // The header byte agrees with the packet kind.
   a_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:8] == 4'd0) |->
         (rsp_tdata[7:0] == (rsp_tuser ? HDR_BIND : HDR_DATA)))
      else $error("header byte does not match packet kind");

   // Bind packets always go out on the bind channel.
   a_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[18:12] == BIND_RF_CHAN))
      else $error("bind packet on wrong radio channel");

endmodule

bind rc_quad_packet_encoder rcqpe_checker u_rcqpe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire
